// ===== rtl/core/fluid_traction_drag_lift_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fluid traction unit
// Immediate-implication and next-cycle-implication forms on clock and reset.
// ----------------------------------------------------------------------------
`ifndef FLUID_TRACTION_DRAG_LIFT_UNIT_MACROS_SVH
`define FLUID_TRACTION_DRAG_LIFT_UNIT_MACROS_SVH

// cons must hold in the same cycle as ante
`define FTDL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define FTDL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ftdl_pkg.sv =====
// ----------------------------------------------------------------------------
// ftdl_pkg
// Types, widths and fixed-point helpers shared by the fluid traction unit.
// ----------------------------------------------------------------------------
package ftdl_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;

   // intermediates are held in [-(2^62-1), 2^62-1]
   localparam int VAL_W   = 64;
   localparam int MAG_W   = VAL_W - 2;
   localparam int EXT_W   = WORD_BITS + 1;
   localparam int PROD_W  = 2 * EXT_W;
   localparam int WIDE_W  = 2 * VAL_W;
   localparam int CFG_W   = WORD_BITS - 1;
   localparam int COLOR_W = 8;
   localparam int CSR_AW  = 2;

   // wide multiplier split
   localparam int SPLIT_W = 32;
   localparam int HI_W    = MAG_W - SPLIT_W;

   // front products and differences
   localparam int NPROD = 14;
   localparam int NDIF  = NPROD / 2;

   // latencies in register stages
   localparam int FRONT_LAT = 5;
   localparam int MUL_LAT   = 6;
   localparam int QUO_BITS  = MAG_W;
   localparam int DIV_LAT   = QUO_BITS + 3;
   localparam int J_DLY     = 2 * MUL_LAT + 1;
   localparam int PM_DLY    = MUL_LAT + 1 + DIV_LAT;
   localparam int SIDE_DLY  = 2 * MUL_LAT + 1 + DIV_LAT;
   localparam int VLD_N     = FRONT_LAT + SIDE_DLY;

   localparam logic signed [VAL_W-1:0] LIM     = {2'b00, {MAG_W{1'b1}}};
   localparam logic [MAG_W-1:0]        MAG_LIM = {MAG_W{1'b1}};
   localparam logic signed [EXT_W-1:0] ONE_EXT = EXT_W'(64'd1 << FRAC_BITS);
   localparam logic signed [WIDE_W-1:0] RND_POS = WIDE_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [WIDE_W-1:0] RND_NEG = RND_POS - WIDE_W'(1);
   localparam logic signed [VAL_W:0] WMAX =
      (VAL_W + 1)'((65'd1 << (WORD_BITS - 1)) - 65'd1);
   localparam logic signed [VAL_W:0] WMIN = -WMAX - (VAL_W + 1)'(1);

   typedef enum logic [CSR_AW-1:0] {
      CSR_DENSITY,
      CSR_VISCOSITY,
      CSR_COLOR_A,
      CSR_COLOR_B
   } csr_index_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] pressure;
      logic signed [WORD_BITS-1:0] disp_grad_xx;
      logic signed [WORD_BITS-1:0] disp_grad_xy;
      logic signed [WORD_BITS-1:0] disp_grad_yx;
      logic signed [WORD_BITS-1:0] disp_grad_yy;
      logic signed [WORD_BITS-1:0] vel_grad_xx;
      logic signed [WORD_BITS-1:0] vel_grad_xy;
      logic signed [WORD_BITS-1:0] vel_grad_yx;
      logic signed [WORD_BITS-1:0] vel_grad_yy;
      logic signed [WORD_BITS-1:0] normal_x;
      logic signed [WORD_BITS-1:0] normal_y;
      logic [COLOR_W-1:0]          boundary_color;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] drag_force;
      logic signed [WORD_BITS-1:0] lift_force;
      logic                        singular;
   } rsp_type;

   typedef struct packed {
      logic zero;
      logic singular;
   } side_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] s00;
      logic signed [VAL_W-1:0] s01;
      logic signed [VAL_W-1:0] s11;
      logic signed [VAL_W-1:0] m0;
      logic signed [VAL_W-1:0] m1;
      logic signed [VAL_W-1:0] jd;
      logic signed [VAL_W-1:0] p;
      side_type                side;
   } front_type;

   // clamp a grown sum to the intermediate range
   function automatic logic signed [VAL_W-1:0] qclamp(input logic signed [VAL_W:0] s);
      logic signed [VAL_W-1:0] r;
      if (s > LIM)
         r = LIM;
      else if (s < -LIM)
         r = -LIM;
      else
         r = s[VAL_W-1:0];
      return r;
   endfunction

   // raw product -> round half away from zero, drop fraction, clamp
   function automatic logic signed [VAL_W-1:0] qround(input logic signed [WIDE_W-1:0] p);
      logic signed [WIDE_W-1:0] t;
      logic signed [WIDE_W-1:0] lim_w;
      logic signed [VAL_W-1:0]  r;
      lim_w = WIDE_W'(LIM);
      t = (p + (p[WIDE_W-1] ? RND_NEG : RND_POS)) >>> FRAC_BITS;
      if (t > lim_w)
         r = LIM;
      else if (t < -lim_w)
         r = -LIM;
      else
         r = t[VAL_W-1:0];
      return r;
   endfunction

   // saturate to the output word
   function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [VAL_W:0] s);
      logic signed [WORD_BITS-1:0] r;
      if (s > WMAX)
         r = WMAX[WORD_BITS-1:0];
      else if (s < WMIN)
         r = WMIN[WORD_BITS-1:0];
      else
         r = s[WORD_BITS-1:0];
      return r;
   endfunction

endpackage

// ===== rtl/core/ftdl_front.sv =====
// ----------------------------------------------------------------------------
// ftdl_front
// Input register, F = I + grad u products, J, C n, G and S = G + G^T.
// ----------------------------------------------------------------------------
module ftdl_front import ftdl_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  req_type            req_data,
   input  logic [COLOR_W-1:0] color_a,
   input  logic [COLOR_W-1:0] color_b,
   output front_type          front
);

   req_type                     in_ff;
   logic signed [PROD_W-1:0]    prod_ff [NPROD];
   logic signed [VAL_W-1:0]     rnd_ff  [NPROD];
   logic signed [VAL_W-1:0]     dif_ff  [NDIF];
   logic signed [WORD_BITS-1:0] p_ff    [3];
   logic                        act_ff  [3];
   front_type                   out_ff;

   logic signed [EXT_W-1:0] op_x [NPROD];
   logic signed [EXT_W-1:0] op_y [NPROD];
   logic signed [EXT_W-1:0] fa, fb, fc, fd;

   always_comb begin
      fa = EXT_W'(in_ff.disp_grad_xx) + ONE_EXT;
      fb = EXT_W'(in_ff.disp_grad_xy);
      fc = EXT_W'(in_ff.disp_grad_yx);
      fd = EXT_W'(in_ff.disp_grad_yy) + ONE_EXT;
      // pairs (2k, 2k+1) are subtracted after rounding
      op_x[0]  = fa;                             op_y[0]  = fd;
      op_x[1]  = fb;                             op_y[1]  = fc;
      op_x[2]  = fd;                             op_y[2]  = EXT_W'(in_ff.normal_x);
      op_x[3]  = fc;                             op_y[3]  = EXT_W'(in_ff.normal_y);
      op_x[4]  = fa;                             op_y[4]  = EXT_W'(in_ff.normal_y);
      op_x[5]  = fb;                             op_y[5]  = EXT_W'(in_ff.normal_x);
      op_x[6]  = EXT_W'(in_ff.vel_grad_xx);      op_y[6]  = fd;
      op_x[7]  = EXT_W'(in_ff.vel_grad_xy);      op_y[7]  = fc;
      op_x[8]  = EXT_W'(in_ff.vel_grad_xy);      op_y[8]  = fa;
      op_x[9]  = EXT_W'(in_ff.vel_grad_xx);      op_y[9]  = fb;
      op_x[10] = EXT_W'(in_ff.vel_grad_yx);      op_y[10] = fd;
      op_x[11] = EXT_W'(in_ff.vel_grad_yy);      op_y[11] = fc;
      op_x[12] = EXT_W'(in_ff.vel_grad_yy);      op_y[12] = fa;
      op_x[13] = EXT_W'(in_ff.vel_grad_yx);      op_y[13] = fb;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff <= req_data;

         for (int i = 0; i < NPROD; i++) begin
            prod_ff[i] <= op_x[i] * op_y[i];
            rnd_ff[i]  <= qround(WIDE_W'(prod_ff[i]));
         end

         for (int k = 0; k < NDIF; k++)
            dif_ff[k] <= qclamp({rnd_ff[2*k][VAL_W-1], rnd_ff[2*k]}
                              - {rnd_ff[2*k+1][VAL_W-1], rnd_ff[2*k+1]});

         p_ff[0]   <= in_ff.pressure;
         p_ff[1]   <= p_ff[0];
         p_ff[2]   <= p_ff[1];
         act_ff[0] <= (in_ff.boundary_color == color_a) ||
                      (in_ff.boundary_color == color_b);
         act_ff[1] <= act_ff[0];
         act_ff[2] <= act_ff[1];

         // dif: jd, m0, m1, g00, g01, g10, g11
         out_ff.jd  <= dif_ff[0];
         out_ff.m0  <= dif_ff[1];
         out_ff.m1  <= dif_ff[2];
         out_ff.s00 <= qclamp({dif_ff[3][VAL_W-1], dif_ff[3]}
                            + {dif_ff[3][VAL_W-1], dif_ff[3]});
         out_ff.s01 <= qclamp({dif_ff[4][VAL_W-1], dif_ff[4]}
                            + {dif_ff[5][VAL_W-1], dif_ff[5]});
         out_ff.s11 <= qclamp({dif_ff[6][VAL_W-1], dif_ff[6]}
                            + {dif_ff[6][VAL_W-1], dif_ff[6]});
         out_ff.p   <= VAL_W'(p_ff[2]);
         out_ff.side.singular <= (dif_ff[0] == '0);
         out_ff.side.zero     <= (dif_ff[0] == '0) || !act_ff[2];
      end
   end

   assign front = out_ff;

endmodule

// ===== rtl/core/ftdl_wmul.sv =====
// ----------------------------------------------------------------------------
// ftdl_wmul
// Pipelined 62x62 magnitude multiply with rounding and saturation.
// ----------------------------------------------------------------------------
module ftdl_wmul import ftdl_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [VAL_W-1:0] x,
   input  logic signed [VAL_W-1:0] y,
   output logic signed [VAL_W-1:0] z
);

   logic [MUL_LAT-2:0]          neg_ff;
   logic [MAG_W-1:0]            mx_ff, my_ff;
   logic [2*SPLIT_W-1:0]        ll_ff, ll3_ff;
   logic [SPLIT_W+HI_W-1:0]     lh_ff, hl_ff;
   logic [2*HI_W-1:0]           hh_ff, hh3_ff;
   logic [SPLIT_W+HI_W:0]       mid_ff;
   logic [2*MAG_W-1:0]          full_ff;
   logic [2*MAG_W-FRAC_BITS:0]  rs_ff;
   logic signed [VAL_W-1:0]     z_ff;

   logic [2*MAG_W:0]            rsum;
   logic [MAG_W-1:0]            smag;

   always_comb begin
      rsum = {1'b0, full_ff} + ((2*MAG_W+1)'(1) << (FRAC_BITS - 1));
      smag = (rs_ff > (2*MAG_W-FRAC_BITS+1)'(MAG_LIM)) ? MAG_LIM : rs_ff[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff <= {neg_ff[MUL_LAT-3:0], x[VAL_W-1] ^ y[VAL_W-1]};
         mx_ff  <= x[VAL_W-1] ? MAG_W'(-x) : MAG_W'(x);
         my_ff  <= y[VAL_W-1] ? MAG_W'(-y) : MAG_W'(y);

         ll_ff  <= mx_ff[SPLIT_W-1:0] * my_ff[SPLIT_W-1:0];
         lh_ff  <= mx_ff[SPLIT_W-1:0] * my_ff[MAG_W-1:SPLIT_W];
         hl_ff  <= mx_ff[MAG_W-1:SPLIT_W] * my_ff[SPLIT_W-1:0];
         hh_ff  <= mx_ff[MAG_W-1:SPLIT_W] * my_ff[MAG_W-1:SPLIT_W];

         mid_ff <= {1'b0, lh_ff} + {1'b0, hl_ff};
         ll3_ff <= ll_ff;
         hh3_ff <= hh_ff;

         full_ff <= {hh3_ff, ll3_ff} + ((2*MAG_W)'(mid_ff) << SPLIT_W);

         rs_ff <= rsum[2*MAG_W:FRAC_BITS];

         z_ff <= neg_ff[MUL_LAT-2] ? -{2'b00, smag} : {2'b00, smag};
      end
   end

   assign z = z_ff;

endmodule

// ===== rtl/core/ftdl_div.sv =====
// ----------------------------------------------------------------------------
// ftdl_div
// Two-lane pipelined restoring divider, one quotient bit per stage,
// shared divisor, round half away from zero, saturating.
// ----------------------------------------------------------------------------
module ftdl_div import ftdl_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [VAL_W-1:0] x0,
   input  logic signed [VAL_W-1:0] x1,
   input  logic signed [VAL_W-1:0] j,
   output logic signed [VAL_W-1:0] q0,
   output logic signed [VAL_W-1:0] q1
);

   logic [MAG_W-1:0]    d_ff  [QUO_BITS+1];
   logic [MAG_W-1:0]    r_ff  [QUO_BITS+1][2];
   logic [QUO_BITS-1:0] q_ff  [QUO_BITS+1][2];
   logic [QUO_BITS-1:0] nl_ff [QUO_BITS+1][2];
   logic [1:0]          neg_ff [QUO_BITS+1];
   logic [1:0]          ovf_ff [QUO_BITS+1];

   logic [QUO_BITS:0]       qr_ff   [2];
   logic [1:0]              negr_ff, ovfr_ff;
   logic signed [VAL_W-1:0] qo_ff   [2];

   logic [MAG_W-1:0]    r_in [QUO_BITS][2];
   logic [QUO_BITS-1:0] q_in [QUO_BITS][2];

   logic signed [VAL_W-1:0] xs [2];
   logic [MAG_W-1:0]        dj;
   logic [MAG_W-1:0]        ax [2];
   logic [MAG_W-1:0]        r0 [2];
   logic [1:0]              up;
   logic [MAG_W-1:0]        smag [2];

   assign xs[0] = x0;
   assign xs[1] = x1;

   always_comb begin
      dj = j[VAL_W-1] ? MAG_W'(-j) : MAG_W'(j);
      for (int l = 0; l < 2; l++) begin
         ax[l] = xs[l][VAL_W-1] ? MAG_W'(-xs[l]) : MAG_W'(xs[l]);
         r0[l] = MAG_W'(ax[l][MAG_W-1 -: FRAC_BITS]);
      end
   end

   // one restoring step per stage
   always_comb begin
      logic [MAG_W:0] t;
      logic           ge;
      for (int k = 0; k < QUO_BITS; k++) begin
         for (int l = 0; l < 2; l++) begin
            t  = {r_ff[k][l], nl_ff[k][l][QUO_BITS-1-k]};
            ge = (t >= {1'b0, d_ff[k]});
            r_in[k][l] = ge ? MAG_W'(t - {1'b0, d_ff[k]}) : MAG_W'(t);
            q_in[k][l] = {q_ff[k][l][QUO_BITS-2:0], ge};
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         up[l]   = (r_ff[QUO_BITS][l] >= (d_ff[QUO_BITS] - r_ff[QUO_BITS][l]));
         smag[l] = (ovfr_ff[l] || (qr_ff[l] > (QUO_BITS+1)'(MAG_LIM)))
                   ? MAG_LIM : qr_ff[l][MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff[0] <= dj;
         for (int l = 0; l < 2; l++) begin
            r_ff[0][l]  <= r0[l];
            q_ff[0][l]  <= '0;
            nl_ff[0][l] <= {ax[l][MAG_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            neg_ff[0][l] <= xs[l][VAL_W-1] ^ j[VAL_W-1];
            ovf_ff[0][l] <= (r0[l] >= dj);
         end

         for (int k = 0; k < QUO_BITS; k++) begin
            d_ff[k+1]   <= d_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            for (int l = 0; l < 2; l++) begin
               r_ff[k+1][l]  <= r_in[k][l];
               q_ff[k+1][l]  <= q_in[k][l];
               nl_ff[k+1][l] <= nl_ff[k][l];
            end
         end

         negr_ff <= neg_ff[QUO_BITS];
         ovfr_ff <= ovf_ff[QUO_BITS];
         for (int l = 0; l < 2; l++) begin
            qr_ff[l] <= {1'b0, q_ff[QUO_BITS][l]} + (QUO_BITS+1)'(up[l]);
            qo_ff[l] <= negr_ff[l] ? -{2'b00, smag[l]} : {2'b00, smag[l]};
         end
      end
   end

   assign q0 = qo_ff[0];
   assign q1 = qo_ff[1];

endmodule

// ===== rtl/core/fluid_traction_drag_lift_unit.sv =====
// ----------------------------------------------------------------------------
// fluid_traction_drag_lift_unit
// Fluid traction (drag, lift) at one 2-D boundary quadrature point, Q16.16.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while req_ready is high and returns one
// response per request, in order. Most of the pipe depth is the 62-stage
// restoring divider that forms (rho nu / J) S m; the front end (5 stages) and
// two 6-stage wide multipliers in series come before it. A stall on the
// response side freezes the whole pipe; while the output register is empty or
// being drained, req_ready is high. rho*nu is recomputed from the registers,
// through kp_ff and then k_ff, after a write.
// Off-color points and points with det F = 0 return zero forces; singular
// flags det F = 0 independently of color.
// ----------------------------------------------------------------------------
`include "fluid_traction_drag_lift_unit_macros.svh"

module fluid_traction_drag_lift_unit import ftdl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CFG_W-1:0]  csr_wdata
);

   // config registers
   logic [CFG_W-1:0]   rho_ff, nu_ff;
   logic [COLOR_W-1:0] color_a_ff, color_b_ff;
   logic [2*CFG_W-1:0] kp_ff;
   logic signed [VAL_W-1:0] k_ff;

   // pipe control
   logic             pipe_en;
   logic [VLD_N-1:0] vld_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   front_type front;

   // S m and p m products
   logic signed [VAL_W-1:0] sm00, sm01, sm10, sm11, pm0, pm1;
   logic signed [VAL_W-1:0] w0_ff, w1_ff;
   logic signed [VAL_W-1:0] kw0, kw1, e0, e1;

   // side lines
   logic signed [VAL_W-1:0] jd_dly_ff  [J_DLY];
   logic signed [VAL_W-1:0] pm0_dly_ff [PM_DLY];
   logic signed [VAL_W-1:0] pm1_dly_ff [PM_DLY];
   side_type                side_dly_ff [SIDE_DLY];

   side_type                side_out;
   logic signed [VAL_W:0]   t0, t1;

   // whole pipe advances unless a finished response is held
   assign pipe_en   = !rsp_valid_ff || rsp_ready;
   assign req_ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rho_ff     <= CFG_W'(65536);
         nu_ff      <= CFG_W'(65536);
         color_a_ff <= COLOR_W'(80);
         color_b_ff <= COLOR_W'(90);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DENSITY:   rho_ff     <= csr_wdata;
            CSR_VISCOSITY: nu_ff      <= csr_wdata;
            CSR_COLOR_A:   color_a_ff <= csr_wdata[COLOR_W-1:0];
            CSR_COLOR_B:   color_b_ff <= csr_wdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // k = rho * nu, rounded
   always_ff @(posedge clock) begin
      kp_ff <= rho_ff * nu_ff;
      k_ff  <= qround(WIDE_W'(kp_ff));
   end

   ftdl_front u_front (
      .clock    (clock),
      .en       (pipe_en),
      .req_data (req_data),
      .color_a  (color_a_ff),
      .color_b  (color_b_ff),
      .front    (front)
   );

   // w = S m, and p m in parallel
   ftdl_wmul u_sm00 (.clock(clock), .en(pipe_en), .x(front.s00), .y(front.m0), .z(sm00));
   ftdl_wmul u_sm01 (.clock(clock), .en(pipe_en), .x(front.s01), .y(front.m1), .z(sm01));
   ftdl_wmul u_sm10 (.clock(clock), .en(pipe_en), .x(front.s01), .y(front.m0), .z(sm10));
   ftdl_wmul u_sm11 (.clock(clock), .en(pipe_en), .x(front.s11), .y(front.m1), .z(sm11));
   ftdl_wmul u_pm0  (.clock(clock), .en(pipe_en), .x(front.p),   .y(front.m0), .z(pm0));
   ftdl_wmul u_pm1  (.clock(clock), .en(pipe_en), .x(front.p),   .y(front.m1), .z(pm1));

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         w0_ff <= qclamp({sm00[VAL_W-1], sm00} + {sm01[VAL_W-1], sm01});
         w1_ff <= qclamp({sm10[VAL_W-1], sm10} + {sm11[VAL_W-1], sm11});
      end
   end

   ftdl_wmul u_kw0 (.clock(clock), .en(pipe_en), .x(k_ff), .y(w0_ff), .z(kw0));
   ftdl_wmul u_kw1 (.clock(clock), .en(pipe_en), .x(k_ff), .y(w1_ff), .z(kw1));

   ftdl_div u_div (
      .clock (clock),
      .en    (pipe_en),
      .x0    (kw0),
      .x1    (kw1),
      .j     (jd_dly_ff[J_DLY-1]),
      .q0    (e0),
      .q1    (e1)
   );

   // side data follows its item through the multipliers and divider
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         jd_dly_ff[0]   <= front.jd;
         side_dly_ff[0] <= front.side;
         pm0_dly_ff[0]  <= pm0;
         pm1_dly_ff[0]  <= pm1;
         for (int i = 1; i < J_DLY; i++)
            jd_dly_ff[i] <= jd_dly_ff[i-1];
         for (int i = 1; i < SIDE_DLY; i++)
            side_dly_ff[i] <= side_dly_ff[i-1];
         for (int i = 1; i < PM_DLY; i++) begin
            pm0_dly_ff[i] <= pm0_dly_ff[i-1];
            pm1_dly_ff[i] <= pm1_dly_ff[i-1];
         end
      end
   end

   // t = p m - e
   always_comb begin
      side_out = side_dly_ff[SIDE_DLY-1];
      t0 = {pm0_dly_ff[PM_DLY-1][VAL_W-1], pm0_dly_ff[PM_DLY-1]} - {e0[VAL_W-1], e0};
      t1 = {pm1_dly_ff[PM_DLY-1][VAL_W-1], pm1_dly_ff[PM_DLY-1]} - {e1[VAL_W-1], e1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         vld_ff       <= {vld_ff[VLD_N-2:0], req_valid};
         rsp_valid_ff <= vld_ff[VLD_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_data_ff.drag_force <= side_out.zero ? '0 : sat_word(t0);
         rsp_data_ff.lift_force <= side_out.zero ? '0 : sat_word(t1);
         rsp_data_ff.singular   <= side_out.singular;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a singular point never carries a force
   `FTDL_ASSERT_NOW(a_singular_zero, rsp_valid && rsp_data.singular, (rsp_data.drag_force == '0) && (rsp_data.lift_force == '0), "singular response with nonzero force")
   // a held response freezes every in-flight valid bit
   `FTDL_ASSERT_NEXT(a_stall_freeze, !pipe_en, vld_ff == $past(vld_ff), "pipe moved during stall")
   // a response appears only when the pipe advanced
   `FTDL_ASSERT_NOW(a_rise_on_move, $rose(rsp_valid_ff), $past(pipe_en), "response without pipe advance")

endmodule

// ===== verif/fluid_traction_drag_lift_unit_tb.sv =====
// ----------------------------------------------------------------------------
// fluid_traction_drag_lift_unit_tb
// Streams boundary points through the traction unit under random idling on
// both channels. Each request's drag, lift and singular flag are predicted in
// saturating fixed point and checked in order. Several density, viscosity and
// color settings are used, including the extremes.
// ----------------------------------------------------------------------------
module fluid_traction_drag_lift_unit_tb;
   import ftdl_pkg::*;

   localparam longint SAT_LIM  = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam int     IDLE_CAP = 6000;   // cycles without any handshake
   localparam int     DRAIN    = 120;    // longer than the pipe latency

   // -------------------------------------------------------------------------
   // Scoreboard: traction predictor plus in-order queue of expected responses
   // -------------------------------------------------------------------------
   class traction_scoreboard;
      longint unsigned density, viscosity;
      logic [COLOR_W-1:0] color_a, color_b;
      rsp_type expected_forces[$];
      int errors;

      function new();
         density = 65536; viscosity = 65536; color_a = 8'd80; color_b = 8'd90;
         errors = 0;
      endfunction

      function logic [127:0] magnitude(longint x);
         longint a;
         a = (x < 0) ? -x : x;
         return {64'd0, a};
      endfunction

      function longint signed_sat(logic [127:0] m, bit neg);
         longint r;
         r = (m > 128'(SAT_LIM)) ? SAT_LIM : longint'(m[63:0]);
         return neg ? -r : r;
      endfunction

      function longint clamp_sum(longint s);
         if (s > SAT_LIM) return SAT_LIM;
         if (s < -SAT_LIM) return -SAT_LIM;
         return s;
      endfunction

      // product rounded half away from zero
      function longint fx_mul(longint x, longint y);
         logic [127:0] p;
         p = magnitude(x) * magnitude(y);
         p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
         return signed_sat(p, (x < 0) != (y < 0));
      endfunction

      function longint fx_div(longint x, longint j);
         logic [127:0] n, d, q, r;
         d = magnitude(j);
         if (d == 0) return 0;
         n = magnitude(x) << FRAC_BITS;
         q = n / d;
         r = n % d;
         if (r >= d - r) q = q + 1;
         return signed_sat(q, (x < 0) != (j < 0));
      endfunction

      function logic signed [WORD_BITS-1:0] to_word(longint x);
         if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
         if (x < -64'sd2147483648) return 32'sh8000_0000;
         return x[WORD_BITS-1:0];
      endfunction

      function rsp_type traction_of(req_type q);
         longint p, a, b, c, d, nx, ny, vxx, vxy, vyx, vyy, jd;
         longint m0, m1, g00, g01, g10, g11, s00, s01, s11, w0, w1, k;
         rsp_type r;
         p = q.pressure;
         a = longint'(q.disp_grad_xx) + 65536; b = q.disp_grad_xy;
         c = q.disp_grad_yx; d = longint'(q.disp_grad_yy) + 65536;
         vxx = q.vel_grad_xx; vxy = q.vel_grad_xy;
         vyx = q.vel_grad_yx; vyy = q.vel_grad_yy;
         nx = q.normal_x; ny = q.normal_y;
         jd = clamp_sum(fx_mul(a, d) - fx_mul(b, c));
         r.singular = (jd == 0);
         r.drag_force = '0;
         r.lift_force = '0;
         if (jd == 0 || !(q.boundary_color == color_a || q.boundary_color == color_b))
            return r;
         m0  = clamp_sum(fx_mul(d, nx) - fx_mul(c, ny));
         m1  = clamp_sum(fx_mul(a, ny) - fx_mul(b, nx));
         g00 = clamp_sum(fx_mul(vxx, d) - fx_mul(vxy, c));
         g01 = clamp_sum(fx_mul(vxy, a) - fx_mul(vxx, b));
         g10 = clamp_sum(fx_mul(vyx, d) - fx_mul(vyy, c));
         g11 = clamp_sum(fx_mul(vyy, a) - fx_mul(vyx, b));
         s00 = clamp_sum(g00 + g00);
         s01 = clamp_sum(g01 + g10);
         s11 = clamp_sum(g11 + g11);
         w0  = clamp_sum(fx_mul(s00, m0) + fx_mul(s01, m1));
         w1  = clamp_sum(fx_mul(s01, m0) + fx_mul(s11, m1));
         k   = fx_mul(longint'(density), longint'(viscosity));
         r.drag_force = to_word(clamp_sum(fx_mul(p, m0) - fx_div(fx_mul(k, w0), jd)));
         r.lift_force = to_word(clamp_sum(fx_mul(p, m1) - fx_div(fx_mul(k, w1), jd)));
         return r;
      endfunction

      function void note_request(req_type q);
         expected_forces = {expected_forces, traction_of(q)};
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_forces.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
            return;
         end
         want = expected_forces.pop_front();
         if (got.drag_force !== want.drag_force) begin
            $display("%0t: drag expected %h actual %h", $time, want.drag_force,
                     got.drag_force);
            errors++;
         end
         if (got.lift_force !== want.lift_force) begin
            $display("%0t: lift expected %h actual %h", $time, want.lift_force,
                     got.lift_force);
            errors++;
         end
         if (got.singular !== want.singular) begin
            $display("%0t: singular expected %b actual %b", $time, want.singular,
                     got.singular);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, DUT and signals
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   req_type req_data = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   traction_scoreboard sb = new();
   bit send_busy = 0;   // no gaps on the request side in burst stretches
   bit drain_busy = 0;  // no stalls on the response side in burst stretches
   int idle_cycles = 0;

   always #10 clock = ~clock;

   fluid_traction_drag_lift_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // response monitor and idle watchdog, both on the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_data);
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_CAP) begin
         $display("fluid_traction_drag_lift_unit verification failed");
         $finish;
      end
   end

   // response side: random stall before each response, none in burst mode
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         stall = drain_busy ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Driver tasks
   // -------------------------------------------------------------------------
   // valid stays high across back-to-back requests; dropped only for a gap
   task automatic send_request(req_type q);
      int gap;
      gap = send_busy ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(q);
      @(negedge clock);
   endtask

   // registers change only with the pipe empty
   task automatic write_csr(csr_index_type idx, logic [CFG_W-1:0] val);
      req_valid <= 1'b0;
      wait (sb.expected_forces.size() == 0);
      repeat (DRAIN) @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DENSITY:   sb.density   = 64'(val);
         CSR_VISCOSITY: sb.viscosity = 64'(val);
         CSR_COLOR_A:   sb.color_a   = val[COLOR_W-1:0];
         CSR_COLOR_B:   sb.color_b   = val[COLOR_W-1:0];
         default: ;
      endcase
      repeat (4) @(negedge clock);   // rho*nu settles through kp_ff and k_ff after a write
   endtask

   // Q16.16 value: mostly near unity, sometimes any 32-bit pattern
   function automatic logic signed [WORD_BITS-1:0] rand_fx();
      case ($urandom_range(0, 5))
         0, 1:    return $urandom();
         2:       return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
         default: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      endcase
   endfunction

   function automatic req_type rand_point();
      req_type q;
      q.pressure = rand_fx();
      q.disp_grad_xx = rand_fx(); q.disp_grad_xy = rand_fx();
      q.disp_grad_yx = rand_fx(); q.disp_grad_yy = rand_fx();
      q.vel_grad_xx = rand_fx(); q.vel_grad_xy = rand_fx();
      q.vel_grad_yx = rand_fx(); q.vel_grad_yy = rand_fx();
      q.normal_x = rand_fx(); q.normal_y = rand_fx();
      // occasionally collapse F so det F is exactly zero
      if ($urandom_range(0, 15) == 0) begin
         q.disp_grad_xx = -32'sd65536;
         q.disp_grad_yy = -32'sd65536;
         q.disp_grad_xy = 0;
      end
      case ($urandom_range(0, 7))
         0, 1, 2: q.boundary_color = sb.color_a;
         3, 4, 5: q.boundary_color = sb.color_b;
         default: q.boundary_color = 8'($urandom_range(0, 255));
      endcase
      return q;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      req_type q;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed points under reset settings
      q = '0; q.boundary_color = 8'd80; send_request(q);              // all zero
      q = '1; q.boundary_color = 8'd80; send_request(q);              // all -1 lsb
      q = '0; q.normal_x = 32'sd65536; q.pressure = 32'sd131072;
      q.vel_grad_xy = 32'sd65536; q.boundary_color = 8'd90; send_request(q);
      q.boundary_color = 8'd81; send_request(q);                      // off color
      q = {{11{32'sh7FFF_FFFF}}, 8'hFF}; q.boundary_color = 8'd80; send_request(q);
      q = {{11{32'sh8000_0000}}, 8'h00}; q.boundary_color = 8'd90; send_request(q);
      q = {{11{32'sh8000_0000}}, 8'h00}; q.normal_x = 32'sh7FFF_FFFF;
      q.boundary_color = 8'd80; send_request(q);                      // mixed extremes
      // singular F, on and off color
      q = '0; q.disp_grad_xx = -32'sd65536; q.disp_grad_yy = -32'sd65536;
      q.normal_x = 32'sd65536; q.pressure = 32'sd65536; q.boundary_color = 8'd80;
      send_request(q);
      q.boundary_color = 8'd0; send_request(q);
      q = '0; q.disp_grad_xy = 32'sd65536; q.disp_grad_yx = 32'sd65536;
      q.normal_y = 32'sd65536; q.boundary_color = 8'd90; send_request(q);
      // det F rounds to zero
      q = '0; q.disp_grad_xx = -32'sd65535; q.disp_grad_yy = -32'sd65535;
      q.normal_x = 32'sd65536; q.boundary_color = 8'd80; send_request(q);
      q = '0; q.disp_grad_xx = 32'sh7FFF_FFFF; q.disp_grad_yy = 32'sh7FFF_FFFF;
      q.pressure = 32'sh7FFF_FFFF; q.normal_x = 32'sh7FFF_FFFF;
      q.vel_grad_yy = 32'sh8000_0000; q.boundary_color = 8'd90; send_request(q);

      // random phases across register settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: begin
               write_csr(CSR_DENSITY, '1);
               write_csr(CSR_VISCOSITY, '1);
               write_csr(CSR_COLOR_A, '0);
               write_csr(CSR_COLOR_B, 31'd255);
            end
            2: begin
               write_csr(CSR_DENSITY, '0);
               write_csr(CSR_VISCOSITY, 31'd98304);
               write_csr(CSR_COLOR_B, '0);       // both colors equal
            end
            3: begin
               write_csr(CSR_DENSITY, 31'd65536);
               write_csr(CSR_VISCOSITY, '0);
               write_csr(CSR_COLOR_A, 31'd255);
            end
            4: begin
               write_csr(CSR_DENSITY, 31'($urandom()));
               write_csr(CSR_VISCOSITY, 31'($urandom_range(0, 32'h0004_0000)));
               write_csr(CSR_COLOR_A, 31'($urandom_range(0, 255)));
               write_csr(CSR_COLOR_B, 31'($urandom_range(0, 255)));
            end
            5: begin
               write_csr(CSR_DENSITY, 31'd1000 << 16);
               write_csr(CSR_VISCOSITY, 31'd66);  // about 0.001
               write_csr(CSR_COLOR_A, 31'd80);
               write_csr(CSR_COLOR_B, 31'd90);
            end
            default: ;
         endcase
         for (int n = 0; n < 106; n++) begin
            if (n % 35 == 0) begin
               send_busy  = ($urandom_range(0, 2) == 0);
               drain_busy = ($urandom_range(0, 2) == 0);
            end
            send_request(rand_point());
         end
         send_busy = 0;
         drain_busy = 0;
      end

      // final drain
      req_valid <= 1'b0;
      wait (sb.expected_forces.size() == 0);
      repeat (DRAIN) @(negedge clock);
      if (sb.errors == 0 && sb.expected_forces.size() == 0)
         $display("fluid_traction_drag_lift_unit verification clean");
      else
         $display("fluid_traction_drag_lift_unit verification failed");
      $finish;
   end

endmodule
